### rtl/core/best_fit_block_allocator_top_macros.svh
// assertion helpers for the block allocator
`ifndef BEST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BFA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("allocator assertion failed");
`define BFA_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("allocator forbidden condition");
`else
`define BFA_ASSERT(lbl, clk, rst, prop)
`define BFA_NEVER(lbl, clk, rst, cond)
`endif
`endif

### rtl/core/bfa_pkg.sv
package bfa_pkg;

   localparam int ARENA_BYTES_DEF  = 65536;
   localparam int HEADER_BYTES_DEF = 32;
   localparam int ALIGN_BYTES      = 16;
   localparam int ALIGN_SHIFT      = 4;
   localparam int REQ_W            = 17;
   localparam int NEED_W           = REQ_W + 1;
   localparam int PTR_W            = 16;
   localparam int REQ_TDATA_W      = 40;
   localparam int RSP_TDATA_W      = 24;

   typedef enum logic [1:0] {
      RD_OFF  = 2'd0,
      RD_B    = 2'd1,
      RD_NXT  = 2'd2,
      RD_PREV = 2'd3
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_SPLIT = 2'd0,
      WR_ALLOC = 2'd1,
      WR_MERGE = 2'd2,
      WR_FREE  = 2'd3
   } wr_sel_type;

   typedef struct packed {
      logic       load;
      logic       walk_init;
      logic       tgt_b;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       alloc_eval;
      logic       walk_step;
      logic       set_b_h;
      logic       set_b_prev;
      logic       latch_b;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       res_load;
      logic       res_ok;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic ptr_zero;
      logic ptr_small;
      logic off_end;
      logic hit;
      logic prev_valid;
      logic best_valid;
      logic do_split;
      logic nxt_end;
      logic rd_free;
      logic res_busy;
   } sts_type;

endpackage

### rtl/core/bfa_ram.sv
module bfa_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bfa_dp.sv
module bfa_dp #(
   parameter int ARENA_BYTES  = 65536,
   parameter int HEADER_BYTES = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_operation,
   input  logic [bfa_pkg::REQ_W-1:0]    req_request_bytes,
   input  logic [bfa_pkg::PTR_W-1:0]    req_block_offset,
   input  bfa_pkg::cmd_type             cmd,
   output bfa_pkg::sts_type             sts,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic                         rsp_ok,
   output logic [bfa_pkg::PTR_W-1:0]    rsp_payload_offset
);

   import bfa_pkg::*;

   localparam int AW     = $clog2(ARENA_BYTES);
   localparam int GW     = AW - ALIGN_SHIFT;
   localparam int NGRAN  = ARENA_BYTES / ALIGN_BYTES;
   localparam int OFF_W  = AW + 1;
   localparam int SIZE_W = AW;
   localparam int DW     = SIZE_W + 1;
   localparam int TGT_W  = (OFF_W > PTR_W) ? OFF_W : PTR_W;
   localparam int CW     = 32;
   localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
   localparam logic [CW-1:0] ARENA_C = CW'(ARENA_BYTES);
   localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(ARENA_BYTES - HEADER_BYTES);

   logic              op_ff;
   logic [NEED_W-1:0] need_ff;
   logic [PTR_W-1:0]  ptr_ff;
   logic [TGT_W-1:0]  h_ff;
   logic [TGT_W-1:0]  target_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [OFF_W-1:0]  prev_ff;
   logic              prev_valid_ff;
   logic [OFF_W-1:0]  best_ff;
   logic              best_valid_ff;
   logic [SIZE_W-1:0] bsize_ff;
   logic [OFF_W-1:0]  b_ff;
   logic [OFF_W-1:0]  nxt_ff;
   logic              g0_written_ff;
   logic              rd0_ff;
   logic              rsp_valid_ff;
   logic              rsp_ok_ff;
   logic [PTR_W-1:0]  rsp_pay_ff;

   logic [NEED_W-1:0] need_in;
   logic [GW-1:0]     rd_addr;
   logic [GW-1:0]     wr_addr;
   logic [DW-1:0]     wr_data;
   logic [DW-1:0]     ram_q;
   logic              rd_free;
   logic [SIZE_W-1:0] rd_size;
   logic [CW-1:0]     adv_sum;
   logic [CW-1:0]     nxt_sum;
   logic [CW-1:0]     nb_sum;
   logic [CW-1:0]     pay_sum;
   logic              fits;
   logic              do_split;

   assign need_in = (NEED_W'(req_request_bytes) + NEED_W'(ALIGN_BYTES - 1))
                    & ~NEED_W'(ALIGN_BYTES - 1);

   // granule zero reads as the reset block until it is first written
   assign rd_free = rd0_ff ? 1'b1 : ram_q[DW-1];
   assign rd_size = rd0_ff ? INIT_SIZE : ram_q[SIZE_W-1:0];

   assign adv_sum  = CW'(off_ff) + HDR_C + CW'(rd_size);
   assign nxt_sum  = CW'(b_ff) + HDR_C + CW'(rd_size);
   assign nb_sum   = CW'(best_ff) + HDR_C + CW'(need_ff);
   assign pay_sum  = CW'(best_ff) + HDR_C;
   assign fits     = CW'(rd_size) >= CW'(need_ff);
   assign do_split = CW'(bsize_ff) > (CW'(need_ff) + HDR_C);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_OFF:  rd_addr = off_ff[AW-1:ALIGN_SHIFT];
         RD_B:    rd_addr = b_ff[AW-1:ALIGN_SHIFT];
         RD_NXT:  rd_addr = nxt_ff[AW-1:ALIGN_SHIFT];
         RD_PREV: rd_addr = prev_ff[AW-1:ALIGN_SHIFT];
         default: rd_addr = off_ff[AW-1:ALIGN_SHIFT];
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         WR_SPLIT: begin
            wr_addr = nb_sum[AW-1:ALIGN_SHIFT];
            wr_data = {1'b1, SIZE_W'(CW'(bsize_ff) - CW'(need_ff) - HDR_C)};
         end
         WR_ALLOC: begin
            wr_addr = best_ff[AW-1:ALIGN_SHIFT];
            wr_data = {1'b0, do_split ? SIZE_W'(need_ff) : bsize_ff};
         end
         WR_MERGE: begin
            wr_addr = b_ff[AW-1:ALIGN_SHIFT];
            wr_data = {1'b1, SIZE_W'(CW'(bsize_ff) + HDR_C + CW'(rd_size))};
         end
         WR_FREE: begin
            wr_addr = b_ff[AW-1:ALIGN_SHIFT];
            wr_data = {1'b1, bsize_ff};
         end
         default: begin
            wr_addr = b_ff[AW-1:ALIGN_SHIFT];
            wr_data = {1'b1, bsize_ff};
         end
      endcase
   end

   bfa_ram #(
      .WIDTH (DW),
      .DEPTH (NGRAN)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         g0_written_ff <= 1'b0;
         rd0_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prev_valid_ff <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_en && (wr_addr == '0)) begin
            g0_written_ff <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd0_ff <= (rd_addr == '0) && !g0_written_ff;
         end
         if (cmd.res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.walk_init) begin
            prev_valid_ff <= 1'b0;
            best_valid_ff <= 1'b0;
         end else begin
            if (cmd.walk_step) begin
               prev_valid_ff <= 1'b1;
            end
            if (cmd.alloc_eval && rd_free && fits &&
                (!best_valid_ff || (rd_size < bsize_ff))) begin
               best_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         need_ff <= need_in;
         ptr_ff  <= req_block_offset;
         h_ff    <= TGT_W'(CW'(req_block_offset) - HDR_C);
      end
      if (cmd.walk_init) begin
         off_ff    <= '0;
         target_ff <= cmd.tgt_b ? TGT_W'(b_ff) : h_ff;
      end
      if (cmd.alloc_eval) begin
         if (rd_free && fits && (!best_valid_ff || (rd_size < bsize_ff))) begin
            best_ff  <= off_ff;
            bsize_ff <= rd_size;
         end
         off_ff <= OFF_W'(adv_sum);
      end
      if (cmd.walk_step) begin
         prev_ff <= off_ff;
         off_ff  <= OFF_W'(adv_sum);
      end
      if (cmd.set_b_h) begin
         b_ff <= OFF_W'(h_ff);
      end
      if (cmd.set_b_prev) begin
         b_ff <= prev_ff;
      end
      if (cmd.latch_b) begin
         bsize_ff <= rd_size;
         nxt_ff   <= OFF_W'(nxt_sum);
      end
      if (cmd.res_load) begin
         rsp_ok_ff  <= cmd.res_ok;
         rsp_pay_ff <= (cmd.res_ok && !op_ff) ? pay_sum[PTR_W-1:0] : '0;
      end
   end

   always_comb begin
      sts.op         = op_ff;
      sts.ptr_zero   = (ptr_ff == '0);
      sts.ptr_small  = CW'(ptr_ff) < HDR_C;
      sts.off_end    = CW'(off_ff) >= ARENA_C;
      sts.hit        = CW'(off_ff) == CW'(target_ff);
      sts.prev_valid = prev_valid_ff;
      sts.best_valid = best_valid_ff;
      sts.do_split   = do_split;
      sts.nxt_end    = CW'(nxt_ff) >= ARENA_C;
      sts.rd_free    = rd_free;
      sts.res_busy   = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_payload_offset = rsp_pay_ff;

endmodule

### rtl/core/bfa_ctrl.sv
module bfa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  bfa_pkg::sts_type sts,
   output bfa_pkg::cmd_type cmd
);

   import bfa_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_DECODE  = 14'b00000000000010,
      S_AL_RD   = 14'b00000000000100,
      S_AL_EVAL = 14'b00000000001000,
      S_AL_END  = 14'b00000000010000,
      S_AL_WR   = 14'b00000000100000,
      S_WK_CHK  = 14'b00000001000000,
      S_WK_STEP = 14'b00000010000000,
      S_MG_RDB  = 14'b00000100000000,
      S_MG_GOTB = 14'b00001000000000,
      S_MG_NXT  = 14'b00010000000000,
      S_MG_GOTN = 14'b00100000000000,
      S_MG_CHKP = 14'b01000000000000,
      S_DONE    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      ok_ff, ok_in;
   logic      merge_ff, merge_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ok_ff    <= 1'b0;
         merge_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ok_ff    <= ok_in;
         merge_ff <= merge_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ok_in    = ok_ff;
      merge_in = merge_ff;
      cmd      = '0;
      cmd.res_ok = ok_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!sts.op) begin
               cmd.walk_init = 1'b1;
               state_in      = S_AL_RD;
            end else if (sts.ptr_zero) begin
               ok_in    = 1'b1;
               state_in = S_DONE;
            end else if (sts.ptr_small) begin
               ok_in    = 1'b0;
               state_in = S_DONE;
            end else begin
               cmd.walk_init = 1'b1;
               merge_in      = 1'b0;
               state_in      = S_WK_CHK;
            end
         end
         S_AL_RD: begin
            if (sts.off_end) begin
               state_in = S_AL_END;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_OFF;
               state_in   = S_AL_EVAL;
            end
         end
         S_AL_EVAL: begin
            cmd.alloc_eval = 1'b1;
            state_in       = S_AL_RD;
         end
         S_AL_END: begin
            if (!sts.best_valid) begin
               ok_in    = 1'b0;
               state_in = S_DONE;
            end else begin
               // carve the tail off as a new free block first
               cmd.wr_en  = sts.do_split;
               cmd.wr_sel = WR_SPLIT;
               state_in   = S_AL_WR;
            end
         end
         S_AL_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_ALLOC;
            ok_in      = 1'b1;
            state_in   = S_DONE;
         end
         S_WK_CHK: begin
            if (sts.off_end) begin
               ok_in    = merge_ff;
               state_in = S_DONE;
            end else if (sts.hit) begin
               if (!merge_ff) begin
                  cmd.set_b_h = 1'b1;
                  state_in    = S_MG_RDB;
               end else if (!sts.prev_valid) begin
                  ok_in    = 1'b1;
                  state_in = S_DONE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_PREV;
                  state_in   = S_MG_CHKP;
               end
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_OFF;
               state_in   = S_WK_STEP;
            end
         end
         S_WK_STEP: begin
            cmd.walk_step = 1'b1;
            state_in      = S_WK_CHK;
         end
         S_MG_RDB: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_B;
            state_in   = S_MG_GOTB;
         end
         S_MG_GOTB: begin
            cmd.latch_b = 1'b1;
            state_in    = S_MG_NXT;
         end
         S_MG_NXT: begin
            if (sts.nxt_end) begin
               cmd.wr_en     = 1'b1;
               cmd.wr_sel    = WR_FREE;
               cmd.walk_init = 1'b1;
               cmd.tgt_b     = 1'b1;
               merge_in      = 1'b1;
               state_in      = S_WK_CHK;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NXT;
               state_in   = S_MG_GOTN;
            end
         end
         S_MG_GOTN: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = sts.rd_free ? WR_MERGE : WR_FREE;
            cmd.walk_init = 1'b1;
            cmd.tgt_b     = 1'b1;
            merge_in      = 1'b1;
            state_in      = S_WK_CHK;
         end
         S_MG_CHKP: begin
            if (sts.rd_free) begin
               cmd.set_b_prev = 1'b1;
               state_in       = S_MG_RDB;
            end else begin
               ok_in    = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!sts.res_busy) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/best_fit_block_allocator_top.sv
// best-fit block allocator over one arena of header-prefixed blocks
// req channel: one transaction per operation; req_tuser is the operation
// (0 allocate, 1 release), req_tdata carries the request size and the
// payload offset to release. rsp channel: one transaction per operation
// with the success flag and the allocated payload offset.
// one operation is in flight at a time; req_tready is high only while the
// controller waits for work.
// allocate: one ram read and one compare per block in the chain, all the
// way to the arena end; every block is at least HEADER_BYTES long.
// release: a chain walk to find the block (a read per block ahead of it),
// then for each merge step a read of the block and its next neighbour and
// a second walk to find the previous block; null and short offsets finish
// without a walk. the block table serves one read per cycle.
// reset leaves one free block spanning the arena, takes effect at once
// and needs no clearing pass.
// a stalled rsp holds its result; the next request can still be taken and
// its result waits in the controller until the output register frees up.
`include "best_fit_block_allocator_top_macros.svh"

module best_fit_block_allocator_top #(
   parameter int ARENA_BYTES  = bfa_pkg::ARENA_BYTES_DEF,
   parameter int HEADER_BYTES = bfa_pkg::HEADER_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // request_bytes [16:0], block_offset [32:17], zero pad
   input  logic [bfa_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // operation
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // ok [0], payload_offset [16:1], zero pad
   output logic [bfa_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   import bfa_pkg::*;

   cmd_type          cmd;
   sts_type          sts;
   logic             rsp_ok;
   logic [PTR_W-1:0] rsp_payload_offset;

   bfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bfa_dp #(
      .ARENA_BYTES  (ARENA_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_operation      (req_tuser),
      .req_request_bytes  (req_tdata[REQ_W-1:0]),
      .req_block_offset   (req_tdata[REQ_W+PTR_W-1:REQ_W]),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_ok             (rsp_ok),
      .rsp_payload_offset (rsp_payload_offset)
   );

   assign rsp_tdata = {(RSP_TDATA_W - PTR_W - 1)'(0), rsp_payload_offset, rsp_ok};

   `BFA_ASSERT(a_one_in_flight, clock, reset, req_tvalid && req_tready |=> !req_tready)
   `BFA_NEVER(a_fail_no_offset, clock, reset, rsp_tvalid && !rsp_tdata[0] && (rsp_tdata[16:1] != 16'd0))
   `BFA_ASSERT(a_result_after_work, clock, reset, $rose(rsp_tvalid) |-> !$past(req_tready))

endmodule

### tb/best_fit_block_allocator_top_test.sv
`timescale 1ns / 1ps

module best_fit_block_allocator_top_test;
   import bfa_pkg::*;

   localparam int ARENA = ARENA_BYTES_DEF;
   localparam int HDR = HEADER_BYTES_DEF;
   localparam int NGRAN = ARENA / ALIGN_BYTES;
   localparam logic [31:0] NO_BLOCK = 32'hFFFF_FFFF;
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_RELEASE = 1'b1;
   localparam int RANDOM_ITEMS = 140;

   typedef struct {
      logic op;
      logic [REQ_W-1:0] req_bytes;
      logic [PTR_W-1:0] offset;
   } alloc_op_type;

   typedef struct {
      logic ok;
      logic [PTR_W-1:0] payload;
   } alloc_result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   best_fit_block_allocator_top uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // shadow block table
   bit start_mark[NGRAN];
   bit free_mark[NGRAN];
   logic [31:0] payload_size[NGRAN];

   alloc_op_type pending_ops[$];
   alloc_result_type expected_results[$];
   logic [PTR_W-1:0] live_offsets[$];
   logic [PTR_W-1:0] released_offsets[$];

   int error_count = 0;
   int ops_sent = 0;
   int results_seen = 0;
   int alloc_fails = 0;
   int bad_releases = 0;
   bit holding = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_phase = 0;
   int stall_mode = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int gran(logic [31:0] off);
      return (off >> 4) % NGRAN;
   endfunction

   function automatic logic [31:0] next_block(logic [31:0] off);
      return off + HDR + payload_size[gran(off)];
   endfunction

   function automatic logic [31:0] find_prev(logic [31:0] target, output bit found);
      logic [31:0] off;
      logic [31:0] prev;
      int n;
      off = 0;
      prev = NO_BLOCK;
      found = 0;
      for (n = 0; n < NGRAN && off < ARENA; n++) begin
         if (off == target) begin
            found = 1;
            return prev;
         end
         prev = off;
         off = next_block(off);
      end
      return NO_BLOCK;
   endfunction

   function automatic logic [31:0] smallest_fit(logic [31:0] need);
      logic [31:0] off;
      logic [31:0] best;
      logic [31:0] best_size;
      int n;
      int g;
      off = 0;
      best = NO_BLOCK;
      best_size = 0;
      for (n = 0; n < NGRAN && off < ARENA; n++) begin
         g = gran(off);
         if (free_mark[g] && payload_size[g] >= need &&
             (best == NO_BLOCK || payload_size[g] < best_size)) begin
            best = off;
            best_size = payload_size[g];
         end
         off = next_block(off);
      end
      return best;
   endfunction

   function automatic void coalesce(logic [31:0] b);
      logic [31:0] nxt;
      logic [31:0] p;
      bit found;
      int gn;
      for (int n = 0; n < NGRAN; n++) begin
         nxt = next_block(b);
         if (nxt < ARENA && free_mark[gran(nxt)]) begin
            gn = gran(nxt);
            payload_size[gran(b)] += HDR + payload_size[gn];
            start_mark[gn] = 0;
            free_mark[gn] = 0;
            payload_size[gn] = 0;
         end
         p = find_prev(b, found);
         if (p != NO_BLOCK && free_mark[gran(p)])
            b = p;
         else
            break;
      end
   endfunction

   function automatic alloc_result_type apply_op(alloc_op_type t);
      alloc_result_type r;
      logic [31:0] need;
      logic [31:0] b;
      logic [31:0] h;
      bit found;
      int g;
      int gn;
      r.ok = 0;
      r.payload = 0;
      if (t.op == OP_ALLOC) begin
         need = (32'(t.req_bytes) + 32'd15) & ~32'd15;
         b = smallest_fit(need);
         if (b == NO_BLOCK) begin
            alloc_fails++;
            return r;
         end
         g = gran(b);
         if (payload_size[g] > need + HDR) begin
            gn = gran(b + HDR + need);
            payload_size[gn] = payload_size[g] - need - HDR;
            free_mark[gn] = 1;
            start_mark[gn] = 1;
            payload_size[g] = need;
         end
         free_mark[g] = 0;
         r.ok = 1;
         r.payload = 16'(b + HDR);
         live_offsets.push_back(r.payload);
      end else begin
         if (t.offset == 0) begin
            r.ok = 1;
            return r;
         end
         if (t.offset < HDR) begin
            bad_releases++;
            return r;
         end
         h = 32'(t.offset) - HDR;
         void'(find_prev(h, found));
         if (!found) begin
            bad_releases++;
            return r;
         end
         free_mark[gran(h)] = 1;
         coalesce(h);
         r.ok = 1;
         foreach (live_offsets[i])
            if (live_offsets[i] == t.offset) begin
               live_offsets.delete(i);
               break;
            end
         released_offsets.push_back(t.offset);
      end
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // driver: bursts of transactions with random gaps
   always @(negedge clock) begin
      alloc_op_type t;
      if (!reset && !holding) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            t = pending_ops.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= t.op;
            req_tdata <= {7'b0, t.offset, t.req_bytes};
            holding = 1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stall pattern: picks among always ready, random ready and mostly stalled modes
   always @(negedge clock) begin
      stall_phase++;
      if (stall_phase % 64 == 0)
         stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // accept requests and check results
   always @(posedge clock) begin
      alloc_op_type t;
      alloc_result_type exp_r;
      if (!reset && req_tvalid && req_tready) begin
         t.op = req_tuser;
         t.req_bytes = req_tdata[16:0];
         t.offset = req_tdata[32:17];
         expected_results.push_back(apply_op(t));
         ops_sent++;
         holding = 0;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("result with no pending operation");
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_tdata[0] !== exp_r.ok)
               report_mismatch($sformatf("ok got %b want %b", rsp_tdata[0], exp_r.ok));
            if (rsp_tdata[16:1] !== exp_r.payload)
               report_mismatch($sformatf("payload_offset got %0d want %0d",
                  rsp_tdata[16:1], exp_r.payload));
         end
      end
   end

   task automatic queue_op(logic op, logic [REQ_W-1:0] bytes, logic [PTR_W-1:0] off);
      alloc_op_type t;
      t.op = op;
      t.req_bytes = bytes;
      t.offset = off;
      pending_ops.push_back(t);
   endtask

   // waits until the previous transaction was taken so the live list is current
   task automatic wait_taken();
      while (pending_ops.size() > 0 || holding) begin
         @(posedge clock);
         #1;
      end
   endtask

   task automatic wait_drained();
      wait_taken();
      while (expected_results.size() > 0) begin
         @(posedge clock);
         #1;
      end
   endtask

   task automatic release_all();
      while (live_offsets.size() > 0) begin
         queue_op(OP_RELEASE, 0, live_offsets[0]);
         wait_drained();
      end
   endtask

   initial begin
      int pick;
      int kind;
      logic [PTR_W-1:0] p;
      for (int i = 0; i < NGRAN; i++) begin
         start_mark[i] = 0;
         free_mark[i] = 0;
         payload_size[i] = 0;
      end
      start_mark[0] = 1;
      free_mark[0] = 1;
      payload_size[0] = ARENA - HDR;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      repeat (4) @(posedge clock);
      #1;
      reset = 1'b0;

      // directed: size edges, null and bad releases, double release, exact fit
      queue_op(OP_ALLOC, 0, 0);
      queue_op(OP_ALLOC, 1, 0);
      queue_op(OP_ALLOC, 16, 0);
      queue_op(OP_ALLOC, 17, 0);
      queue_op(OP_ALLOC, 17'h10000, 16'hFFFF);
      queue_op(OP_ALLOC, 17'h0FFFF, 0);
      queue_op(OP_RELEASE, 17'h1FFFF, 0);
      queue_op(OP_RELEASE, 0, 16'd5);
      queue_op(OP_RELEASE, 0, 16'hFFFF);
      wait_drained();
      p = live_offsets[1];
      queue_op(OP_RELEASE, 0, PTR_W'(p + 16'd16));
      queue_op(OP_RELEASE, 0, p);
      queue_op(OP_RELEASE, 0, p);
      wait_drained();
      release_all();
      queue_op(OP_ALLOC, REQ_W'(ARENA - HDR), 0);
      queue_op(OP_ALLOC, 0, 0);
      wait_drained();
      release_all();

      // random: mostly well-formed alloc/release mixes, some noise
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         wait_taken();
         if (i == RANDOM_ITEMS / 2)
            wait_drained();
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               queue_op(OP_ALLOC, REQ_W'($urandom_range(0, 17'h1FFFF)), PTR_W'($urandom));
            else if (pick < 3)
               queue_op(OP_ALLOC, REQ_W'($urandom_range(0, 8192)), PTR_W'($urandom));
            else
               queue_op(OP_ALLOC, REQ_W'($urandom_range(0, 600)), 0);
         end else if (kind < 88 && live_offsets.size() > 0) begin
            queue_op(OP_RELEASE, REQ_W'($urandom),
               live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
         end else if (kind < 92 && released_offsets.size() > 0) begin
            queue_op(OP_RELEASE, 0,
               released_offsets[$urandom_range(0, released_offsets.size() - 1)]);
         end else if (kind < 96) begin
            queue_op(OP_RELEASE, 0, PTR_W'($urandom));
         end else begin
            queue_op(OP_RELEASE, 0, PTR_W'($urandom_range(0, 40)));
         end
      end
      wait_drained();
      repeat (200) @(posedge clock);
      $display("ran %0d operations, %0d results checked", ops_sent, results_seen);
      $display("%0d allocations found no fit, %0d releases were rejected",
         alloc_fails, bad_releases);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("FAIL");
      $finish;
   end

endmodule

### best_fit_block_allocator_top.f
+incdir+rtl/core
rtl/core/bfa_pkg.sv
rtl/core/bfa_ram.sv
rtl/core/bfa_dp.sv
rtl/core/bfa_ctrl.sv
rtl/core/best_fit_block_allocator_top.sv
tb/best_fit_block_allocator_top_test.sv
